// File: hw/rtl/polynomial_basis_generator_core_macros.svh
// Assertion macros used by the polynomial basis generator checker.
`ifndef POLYNOMIAL_BASIS_GENERATOR_CORE_MACROS_SVH
`define POLYNOMIAL_BASIS_GENERATOR_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PBG_ASSERT(LBL, CLK, RSTN, PROP, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (PROP)) \
    else $error(MSG);

// Condition that must never be seen outside reset.
`define PBG_NEVER(LBL, CLK, RSTN, COND, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) !(COND)) \
    else $error(MSG);

`endif

// File: hw/rtl/pbg_pkg.sv
// Types, constants and saturation helpers of the polynomial basis generator.
package pbg_pkg;

  localparam int COORD_W = 32;
  localparam int VALUE_W = 64;
  localparam int INDEX_W = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_KIND = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 8'd3;

  localparam logic [1:0] KIND_POWER     = 2'd0;
  localparam logic [1:0] KIND_LEGENDRE  = 2'd1;
  localparam logic [1:0] KIND_CHEBYSHEV = 2'd2;

  localparam logic [3:0] TERM_COUNT_RST = 4'd4;

  localparam logic [VALUE_W-1:0] Q_ONE = 64'h0000_0001_0000_0000;
  localparam logic [VALUE_W-1:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;

  // Magnitude of a two's complement word; the most negative value maps to 2^63.
  function automatic logic [VALUE_W-1:0] mag64(logic [VALUE_W-1:0] a);
    return a[VALUE_W-1] ? (~a + 64'd1) : a;
  endfunction

  // Apply a sign to a magnitude and clamp to the signed Q32.32 range.
  function automatic logic [VALUE_W-1:0] sat_mag(logic ovf, logic [VALUE_W-1:0] m,
                                                 logic neg);
    logic [VALUE_W-1:0] res;
    if (ovf) begin
      res = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      res = m[VALUE_W-1] ? Q_MIN : (~m + 64'd1);
    end else begin
      res = m[VALUE_W-1] ? Q_MAX : m;
    end
    return res;
  endfunction

  // Clamp a 65-bit signed sum back to 64 bits.
  function automatic logic [VALUE_W-1:0] sat65(logic [VALUE_W:0] v);
    logic [VALUE_W-1:0] res;
    if (v[VALUE_W] != v[VALUE_W-1]) begin
      res = v[VALUE_W] ? Q_MIN : Q_MAX;
    end else begin
      res = v[VALUE_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/pbg_if.sv
// Valid/ready channel interfaces for the coordinate input and the term output.
interface pbg_in_if import pbg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord;

  modport source (output valid, output coord, input ready);
  modport sink (input valid, input coord, output ready);
endinterface

interface pbg_out_if import pbg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [INDEX_W-1:0] term_index;
  logic signed [VALUE_W-1:0] term_value;
  logic                      last_term;

  modport source (output valid, output term_index, output term_value, output last_term,
                  input ready);
  modport sink (input valid, input term_index, input term_value, input last_term,
                output ready);
endinterface

// File: hw/rtl/polynomial_basis_generator_core.sv
// Polynomial basis generator: power, Legendre and Chebyshev terms of one coordinate.
//
// Usage: a signed Q16.16 coordinate enters on in_ch; the block answers with a run of
// term_count words (at least one, at most MAX_TERMS) on out_ch (degree 0 upward, signed
// Q32.32, last word marked by last_term). The user writes the configuration (basis_kind,
// term_count, range_min, range_max) through cfg_we/cfg_index/cfg_wdata only while the
// block is idle; the block does not enforce this. Unknown indexes are ignored. in_ch.ready
// is high only while no coordinate is being worked on. Products run on one shared 32x32
// multiplier (four partial products and an accumulate per 64-bit product), quotients on
// one radix-2 divider. The first word needs no arithmetic, or a division when Legendre or
// Chebyshev mode normalizes by the range. In those two modes the degree-one word is the
// normalized coordinate itself. Each further word takes one product in power mode, a
// product, a doubling and a subtraction in Chebyshev mode, and three products, a
// subtraction and a division by the degree in Legendre mode.
// A stalled receiver holds the current word in the output register and the sequencer
// waits; the next coordinate may be accepted while the final word is still waiting.
// Reset (rst_n low at a clock edge) returns to idle, drops any pending word and loads
// the register reset values.
module polynomial_basis_generator_core import pbg_pkg::*; #(
  parameter int MAX_TERMS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pbg_in_if.sink                in_ch,
  pbg_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_TERMS);
  localparam int DIV_STEPS = VALUE_W + 1;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_DIV_END, ST_EMIT, ST_MUL,
    ST_CHEB, ST_CHEB_SUB, ST_LEG_A, ST_LEG_B, ST_LEG_D, ST_LEG_E
  } state_t;

  typedef enum logic [1:0] {
    MOP_POW, MOP_XN, MOP_SCALE_A, MOP_SCALE_B
  } mop_t;

  // Configuration registers.
  logic [1:0]                kind_r;
  logic [3:0]                tcount_r;
  logic signed [COORD_W-1:0] rmin_r;
  logic signed [COORD_W-1:0] rmax_r;

  state_t             state_r;
  logic [COORD_W-1:0] x_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   last_idx_r;
  logic [VALUE_W-1:0] xn_r;
  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] t1_r;
  logic [VALUE_W-1:0] t2_r;
  logic [VALUE_W-1:0] tmp_r;
  logic [VALUE_W-1:0] sc_r;

  // Shared multiplier.
  mop_t                 mop_r;
  logic [2:0]           mstep_r;
  logic [VALUE_W-1:0]   mul_a_r;
  logic [VALUE_W-1:0]   mul_b_r;
  logic                 mul_neg_r;
  logic [VALUE_W-1:0]   pp_r;
  logic [1:0]           ppsh_r;
  logic [2*VALUE_W-1:0] acc_r;

  // Shared divider.
  logic [DCNT_W-1:0] dcnt_r;
  logic [VALUE_W:0]  dvd_r;
  logic [31:0]       rem_r;
  logic [31:0]       dsr_r;
  logic              div_neg_r;
  logic              div_leg_r;

  // Output register.
  logic               out_valid_r;
  logic [INDEX_W-1:0] out_index_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_last_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 poly_mode;
  logic [VALUE_W-1:0]   xq;
  logic [31:0]          tc_ext;
  logic [31:0]          n_terms;
  logic [31:0]          idx_ext;
  logic [CNT_W-1:0]     idx_nxt;
  logic [34:0]          num;
  logic [32:0]          den;
  logic [34:0]          num_mag;
  logic [32:0]          den_mag;
  logic                 norm_neg;
  logic [31:0]          a_part;
  logic [31:0]          b_part;
  logic [2*VALUE_W-1:0] pp_shifted;
  logic [VALUE_W-1:0]   qres;
  logic [VALUE_W-1:0]   sres;
  logic [32:0]          div_sh;
  logic                 div_ge;
  logic [32:0]          div_diff;
  logic [VALUE_W-1:0]   dres;
  logic [CNT_W:0]       k_a;
  logic [CNT_W-1:0]     k_b;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign poly_mode = (kind_r == KIND_LEGENDRE) || (kind_r == KIND_CHEBYSHEV);
  assign xq        = {{16{x_r[COORD_W-1]}}, x_r, 16'd0};

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.term_index = out_index_r;
  assign out_ch.term_value = out_value_r;
  assign out_ch.last_term  = out_last_r;

  // Terms per run: a zero count gives one term, large counts stop at MAX_TERMS.
  always_comb begin
    tc_ext = 32'(tcount_r);
    if (tc_ext == 32'd0) begin
      n_terms = 32'd1;
    end else if (tc_ext > 32'(MAX_TERMS)) begin
      n_terms = 32'(MAX_TERMS);
    end else begin
      n_terms = tc_ext;
    end
  end

  assign idx_ext = 32'(idx_r);
  assign idx_nxt = idx_r + CNT_W'(1);
  assign k_a     = {idx_r, 1'b0} - (CNT_W + 1)'(1);
  assign k_b     = idx_r - CNT_W'(1);

  // Normalization operands: 2x - (max + min) over max - min.
  always_comb begin
    num      = {{2{x_r[COORD_W-1]}}, x_r, 1'b0} - 35'(rmax_r) - 35'(rmin_r);
    den      = 33'(rmax_r) - 33'(rmin_r);
    num_mag  = num[34] ? (~num + 35'd1) : num;
    den_mag  = den[32] ? (~den + 33'd1) : den;
    norm_neg = num[34] != den[32];
  end

  // Partial product order: a0*b0, a0*b1, a1*b0, a1*b1.
  always_comb begin
    a_part = mstep_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
    b_part = mstep_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];
    case (ppsh_r)
      2'd0:    pp_shifted = {64'd0, pp_r};
      2'd1:    pp_shifted = {32'd0, pp_r, 32'd0};
      default: pp_shifted = {pp_r, 64'd0};
    endcase
    qres = sat_mag(acc_r[127:96] != 32'd0, acc_r[95:32], mul_neg_r);
    sres = sat_mag(acc_r[127:64] != 64'd0, acc_r[63:0], mul_neg_r);
  end

  // One restoring division step per cycle; quotient bits shift into dvd_r.
  always_comb begin
    div_sh   = {rem_r, dvd_r[VALUE_W]};
    div_diff = div_sh - {1'b0, dsr_r};
    div_ge   = div_sh >= {1'b0, dsr_r};
    dres     = sat_mag(dvd_r[VALUE_W], dvd_r[VALUE_W-1:0], div_neg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_POWER;
      tcount_r    <= TERM_COUNT_RST;
      rmin_r      <= '0;
      rmax_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASIS_KIND: kind_r   <= cfg_wdata[1:0];
          CFG_TERM_COUNT: tcount_r <= cfg_wdata[3:0];
          CFG_RANGE_MIN:  rmin_r   <= cfg_wdata;
          CFG_RANGE_MAX:  rmax_r   <= cfg_wdata;
          default: ;
        endcase
      end

      // In ST_EMIT the output register is reloaded or left waiting below.
      if (out_valid_r && out_ch.ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            x_r        <= in_ch.coord;
            last_idx_r <= CNT_W'(n_terms - 32'd1);
            state_r    <= ST_PREP;
          end
        end

        ST_PREP: begin
          idx_r   <= '0;
          value_r <= Q_ONE;
          if (poly_mode && (rmin_r != '0 || rmax_r != '0)) begin
            if (den == 33'd0) begin
              // Equal nonzero bounds: the quotient is infinite.
              xn_r    <= num[34] ? Q_MIN : Q_MAX;
              state_r <= ST_EMIT;
            end else begin
              dvd_r     <= {num_mag[32:0], 32'd0};
              dsr_r     <= den_mag[31:0];
              rem_r     <= '0;
              dcnt_r    <= '0;
              div_neg_r <= norm_neg;
              div_leg_r <= 1'b0;
              state_r   <= ST_DIV;
            end
          end else begin
            xn_r    <= xq;
            state_r <= ST_EMIT;
          end
        end

        ST_DIV: begin
          rem_r  <= div_ge ? div_diff[31:0] : div_sh[31:0];
          dvd_r  <= {dvd_r[VALUE_W-1:0], div_ge};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_DIV_END;
          end
        end

        ST_DIV_END: begin
          if (div_leg_r) begin
            value_r <= dres;
          end else begin
            xn_r    <= dres;
            value_r <= Q_ONE;
          end
          state_r <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_index_r <= idx_ext[INDEX_W-1:0];
            out_value_r <= value_r;
            out_last_r  <= (idx_r == last_idx_r);
            if (idx_r == last_idx_r) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_nxt;
              t1_r  <= value_r;
              t2_r  <= t1_r;
              if (poly_mode && idx_r == '0) begin
                value_r <= xn_r;
              end else begin
                mul_a_r   <= mag64(poly_mode ? xn_r : xq);
                mul_b_r   <= mag64(value_r);
                mul_neg_r <= (poly_mode ? xn_r[63] : xq[63]) ^ value_r[63];
                mop_r     <= poly_mode ? MOP_XN : MOP_POW;
                mstep_r   <= '0;
                acc_r     <= '0;
                state_r   <= ST_MUL;
              end
            end
          end
        end

        ST_MUL: begin
          if (mstep_r < 3'd4) begin
            pp_r   <= 64'(a_part) * 64'(b_part);
            ppsh_r <= 2'(mstep_r[1]) + 2'(mstep_r[0]);
          end
          if (mstep_r != 3'd0 && mstep_r < 3'd5) begin
            acc_r <= acc_r + pp_shifted;
          end
          mstep_r <= mstep_r + 3'd1;
          if (mstep_r == 3'd5) begin
            case (mop_r)
              MOP_POW: begin
                value_r <= qres;
                state_r <= ST_EMIT;
              end
              MOP_XN: begin
                tmp_r   <= qres;
                state_r <= (kind_r == KIND_CHEBYSHEV) ? ST_CHEB : ST_LEG_A;
              end
              MOP_SCALE_A: begin
                tmp_r   <= sres;
                state_r <= ST_LEG_B;
              end
              MOP_SCALE_B: begin
                sc_r    <= sres;
                state_r <= ST_LEG_D;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end

        ST_CHEB: begin
          tmp_r   <= sat65({tmp_r, 1'b0});
          state_r <= ST_CHEB_SUB;
        end

        ST_CHEB_SUB: begin
          value_r <= sat65({tmp_r[63], tmp_r} - {t2_r[63], t2_r});
          state_r <= ST_EMIT;
        end

        ST_LEG_A: begin
          mul_a_r   <= mag64(tmp_r);
          mul_b_r   <= 64'(k_a);
          mul_neg_r <= tmp_r[63];
          mop_r     <= MOP_SCALE_A;
          mstep_r   <= '0;
          acc_r     <= '0;
          state_r   <= ST_MUL;
        end

        ST_LEG_B: begin
          mul_a_r   <= mag64(t2_r);
          mul_b_r   <= 64'(k_b);
          mul_neg_r <= t2_r[63];
          mop_r     <= MOP_SCALE_B;
          mstep_r   <= '0;
          acc_r     <= '0;
          state_r   <= ST_MUL;
        end

        ST_LEG_D: begin
          tmp_r   <= sat65({tmp_r[63], tmp_r} - {sc_r[63], sc_r});
          state_r <= ST_LEG_E;
        end

        ST_LEG_E: begin
          // Divide by the degree, truncating toward zero.
          dvd_r     <= {1'b0, mag64(tmp_r)};
          dsr_r     <= idx_ext;
          rem_r     <= '0;
          dcnt_r    <= '0;
          div_neg_r <= tmp_r[63];
          div_leg_r <= 1'b1;
          state_r   <= ST_DIV;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/pbg_checker.sv
// Port-level checker for the polynomial basis generator, bound to polynomial_basis_generator_core.
`include "polynomial_basis_generator_core_macros.svh"

module pbg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [2:0]  out_index,
  input logic [63:0] out_value
);

  // A run is never open while a new coordinate could be taken.
  `PBG_NEVER(a_ready_mid_run, clk, rst_n,
    in_ready && out_valid && !out_last, "run open while ready")

  // Once a coordinate is taken the block is busy on the next cycle.
  `PBG_ASSERT(a_busy_after_accept, clk, rst_n,
    (in_valid && in_ready) |=> !in_ready, "ready after accept")

  // The word after the final one of a run opens a new run at degree zero.
  `PBG_ASSERT(a_run_restart, clk, rst_n,
    (out_valid && out_ready && out_last) |=> (!out_valid || out_index == 3'd0),
    "run after last does not start at degree zero")

  // A stalled word holds.
  `PBG_ASSERT(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index) &&
      $stable(out_value) && $stable(out_last)),
    "stalled word changed")

endmodule

bind polynomial_basis_generator_core pbg_checker u_pbg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_term),
  .out_index (out_ch.term_index),
  .out_value (out_ch.term_value)
);
